@@ rtl/dtd_pkg.sv @@
package dtd_pkg;

    localparam int unsigned DTD_MAX_YEAR = 9999;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int POINT_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int IN_W     = 2 * POINT_W;
    localparam int OUT_W    = 40;

    localparam int DBY_W = 23;  // days before a year, up to year 16383
    localparam int DOY_W = 9;   // zero-based day of year
    localparam int TOD_W = 17;  // seconds into the day, linear in raw fields

    // reciprocal of 25, exact for dividends below 43690
    localparam int RECIP_SHIFT = 18;
    localparam int unsigned RECIP25 = ((1 << RECIP_SHIFT) + 24) / 25;

    localparam int unsigned SECS_PER_DAY = 86400;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_adv_t;

    // days of the months before the given month; month zero reads as January,
    // months above twelve as December
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            default:    d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/dtd_point.sv @@
// Three-stage conversion of one date-time into day and second counts.
module dtd_point #(
    parameter int unsigned MAX_YEAR = dtd_pkg::DTD_MAX_YEAR
) (
    input  logic                             clk,
    input  dtd_pkg::stage_adv_t              adv,
    input  logic [dtd_pkg::YEAR_W-1:0]       year,
    input  logic [dtd_pkg::MONTH_W-1:0]      month,
    input  logic [dtd_pkg::DAY_W-1:0]        day,
    input  logic [dtd_pkg::HOUR_W-1:0]       hour,
    input  logic [dtd_pkg::MINUTE_W-1:0]     minute,
    input  logic [dtd_pkg::SECOND_W-1:0]     second,
    output logic [dtd_pkg::YEAR_W-1:0]       year_out,
    output logic [dtd_pkg::DBY_W-1:0]        dby,
    output logic [dtd_pkg::DOY_W-1:0]        doy,
    output logic [dtd_pkg::TOD_W-1:0]        tod
);

    localparam int YW = dtd_pkg::YEAR_W;
    localparam logic [16:0] MAX_YEAR_W = 17'(MAX_YEAR);

    // stage 1
    logic [YW-1:0]               y1_reg, y1_next;
    logic                        feb1_reg, feb1_next;
    logic [dtd_pkg::DOY_W-1:0]   dmd1_reg, dmd1_next;
    logic [dtd_pkg::TOD_W-1:0]   tod1_reg, tod1_next;
    logic [12:0]                 n100_reg, n100_next;
    logic [10:0]                 n400_reg, n400_next;
    logic [dtd_pkg::DAY_W-1:0]   day0;

    always_comb
    begin
        // saturate the year
        if ({3'b0, year} > MAX_YEAR_W)
            y1_next = YW'(MAX_YEAR);
        else
            y1_next = year;
        day0      = (day == '0) ? '0 : day - 5'd1;
        feb1_next = (month >= 4'd3);
        dmd1_next = dtd_pkg::days_before_month(month) + dtd_pkg::DOY_W'(day0);
        tod1_next = dtd_pkg::TOD_W'(hour) * 17'd3600
                  + dtd_pkg::TOD_W'(minute) * 17'd60
                  + dtd_pkg::TOD_W'(second);
        n100_next = 13'((15'(y1_next) + 15'd99) >> 2);
        n400_next = 11'((15'(y1_next) + 15'd399) >> 4);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            y1_reg   <= y1_next;
            feb1_reg <= feb1_next;
            dmd1_reg <= dmd1_next;
            tod1_reg <= tod1_next;
            n100_reg <= n100_next;
            n400_reg <= n400_next;
        end
    end

    // stage 2: divide by 25 through the reciprocal
    logic [YW-1:0]               y2_reg;
    logic                        feb2_reg;
    logic [dtd_pkg::DOY_W-1:0]   dmd2_reg;
    logic [dtd_pkg::TOD_W-1:0]   tod2_reg;
    logic [dtd_pkg::DBY_W-1:0]   base2_reg, base2_next;
    logic [8:0]                  q100_reg, q100_next;
    logic [6:0]                  q400_reg, q400_next;
    logic [9:0]                  q25_reg, q25_next;
    logic [26:0]                 p100;
    logic [24:0]                 p400;
    logic [27:0]                 p25;

    always_comb
    begin
        p100       = 27'(n100_reg) * 27'(dtd_pkg::RECIP25);
        p400       = 25'(n400_reg) * 25'(dtd_pkg::RECIP25);
        p25        = 28'(y1_reg) * 28'(dtd_pkg::RECIP25);
        q100_next  = p100[26:18];
        q400_next  = p400[24:18];
        q25_next   = p25[27:18];
        base2_next = dtd_pkg::DBY_W'(y1_reg) * 23'd365
                   + dtd_pkg::DBY_W'((15'(y1_reg) + 15'd3) >> 2);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            y2_reg    <= y1_reg;
            feb2_reg  <= feb1_reg;
            dmd2_reg  <= dmd1_reg;
            tod2_reg  <= tod1_reg;
            base2_reg <= base2_next;
            q100_reg  <= q100_next;
            q400_reg  <= q400_next;
            q25_reg   <= q25_next;
        end
    end

    // stage 3: leap rule and final counts
    logic                        leap;
    logic [dtd_pkg::DBY_W-1:0]   dby_next;
    logic [dtd_pkg::DOY_W-1:0]   doy_next;
    logic [YW-1:0]               y3_reg;
    logic [dtd_pkg::DBY_W-1:0]   dby_reg;
    logic [dtd_pkg::DOY_W-1:0]   doy_reg;
    logic [dtd_pkg::TOD_W-1:0]   tod_reg;

    always_comb
    begin
        // a multiple of 100 is a multiple of 4 and of 25
        leap = (y2_reg[1:0] == 2'b00)
            && ((y2_reg != YW'(q25_reg) * YW'(25)) || (y2_reg[3:0] == 4'b0000));
        dby_next = base2_reg - dtd_pkg::DBY_W'(q100_reg) + dtd_pkg::DBY_W'(q400_reg);
        doy_next = dmd2_reg + dtd_pkg::DOY_W'(feb2_reg && leap);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            y3_reg  <= y2_reg;
            dby_reg <= dby_next;
            doy_reg <= doy_next;
            tod_reg <= tod2_reg;
        end
    end

    assign year_out = y3_reg;
    assign dby      = dby_reg;
    assign doy      = doy_reg;
    assign tod      = tod_reg;

endmodule

@@ rtl/datetime_difference_seconds.sv @@
// Signed seconds between two Gregorian date-times. Each item carries a start
// and an end date-time; the result is end minus start in seconds, counting
// whole years between them with the Gregorian leap rule (a year term of zero
// when the end year is not after the start year) plus the offsets within
// each year. Years above MAX_YEAR saturate, month zero counts as January,
// months above twelve as December, day zero as day one; other out-of-range
// fields are used linearly. The block is a five-stage pipeline of the three
// conversion stages, the difference stage and the seconds-per-day multiply
// stage; it takes one item every cycle while the output is not held back.
// Back-pressure on the output holds the pipeline without losing or
// repeating any item; empty stages fill up first.
module datetime_difference_seconds #(
    parameter int unsigned MAX_YEAR = dtd_pkg::DTD_MAX_YEAR
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // start_year, start_month, start_day, start_hour, start_minute,
    // start_second, end_year, end_month, end_day, end_hour, end_minute,
    // end_second (from bit 0 up)
    input  logic [dtd_pkg::IN_W-1:0]    s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // elapsed_seconds (signed)
    output logic [dtd_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int PW = dtd_pkg::POINT_W;
    localparam logic signed [41:0] OUT_MAX = 42'sd549755813887;
    localparam logic signed [41:0] OUT_MIN = -42'sd549755813888;

    // Valid bit per stage; a stage takes new data when it is empty or its
    // successor moves on.
    logic [4:0] v_reg, v_next;
    logic [4:0] rdy;

    always_comb
    begin
        rdy[4] = !v_reg[4] || m_axis_tready;
        rdy[3] = !v_reg[3] || rdy[4];
        rdy[2] = !v_reg[2] || rdy[3];
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
        v_next[0] = rdy[0] ? s_axis_tvalid : v_reg[0];
        v_next[1] = rdy[1] ? v_reg[0] : v_reg[1];
        v_next[2] = rdy[2] ? v_reg[1] : v_reg[2];
        v_next[3] = rdy[3] ? v_reg[2] : v_reg[3];
        v_next[4] = rdy[4] ? v_reg[3] : v_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign s_axis_tready = rdy[0];

    dtd_pkg::stage_adv_t adv;
    assign adv.s1 = rdy[0];
    assign adv.s2 = rdy[1];
    assign adv.s3 = rdy[2];

    // Convert both ends in parallel.
    logic [dtd_pkg::YEAR_W-1:0] sy, ey;
    logic [dtd_pkg::DBY_W-1:0]  sdby, edby;
    logic [dtd_pkg::DOY_W-1:0]  sdoy, edoy;
    logic [dtd_pkg::TOD_W-1:0]  stod, etod;

    dtd_point #(.MAX_YEAR(MAX_YEAR)) u_start (
        .clk      (clk),
        .adv      (adv),
        .year     (s_axis_tdata[13:0]),
        .month    (s_axis_tdata[17:14]),
        .day      (s_axis_tdata[22:18]),
        .hour     (s_axis_tdata[27:23]),
        .minute   (s_axis_tdata[33:28]),
        .second   (s_axis_tdata[39:34]),
        .year_out (sy),
        .dby      (sdby),
        .doy      (sdoy),
        .tod      (stod)
    );

    dtd_point #(.MAX_YEAR(MAX_YEAR)) u_end (
        .clk      (clk),
        .adv      (adv),
        .year     (s_axis_tdata[PW+13:PW]),
        .month    (s_axis_tdata[PW+17:PW+14]),
        .day      (s_axis_tdata[PW+22:PW+18]),
        .hour     (s_axis_tdata[PW+27:PW+23]),
        .minute   (s_axis_tdata[PW+33:PW+28]),
        .second   (s_axis_tdata[PW+39:PW+34]),
        .year_out (ey),
        .dby      (edby),
        .doy      (edoy),
        .tod      (etod)
    );

    // Stage 4: day and second differences. Drop the year term unless the
    // end year is later.
    logic signed [23:0] dd_reg, dd_next;
    logic signed [17:0] sd_reg, sd_next;
    logic signed [23:0] year_days;

    always_comb
    begin
        if (ey > sy)
            year_days = $signed({1'b0, edby}) - $signed({1'b0, sdby});
        else
            year_days = '0;
        dd_next = year_days + 24'($signed({1'b0, edoy})) - 24'($signed({1'b0, sdoy}));
        sd_next = $signed({1'b0, etod}) - $signed({1'b0, stod});
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            dd_reg <= dd_next;
            sd_reg <= sd_next;
        end
    end

    // Stage 5: scale days to seconds, add the in-day difference, saturate.
    logic signed [41:0]          total;
    logic [dtd_pkg::OUT_W-1:0]   out_reg, out_next;

    always_comb
    begin
        total = 42'(dd_reg) * $signed(42'(dtd_pkg::SECS_PER_DAY)) + 42'(sd_reg);
        if (total > OUT_MAX)
            out_next = OUT_MAX[39:0];
        else if (total < OUT_MIN)
            out_next = OUT_MIN[39:0];
        else
            out_next = total[39:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
            out_reg <= out_next;
    end

    assign m_axis_tvalid = v_reg[4];
    assign m_axis_tdata  = out_reg;

endmodule
